/* hdl/ictt_pkg.sv */
// Package with shared constants and types of the idle connection timeout table.
package ictt_pkg;
  localparam int TableDepth = 64;
  localparam int SlotBits   = $clog2(TableDepth);
  localparam int CountBits  = $clog2(TableDepth + 1);
  localparam int IdBits     = 16;
  localparam logic [31:0] TimeoutReset = 32'd60;

  typedef enum logic [1:0] {
    FUNC_TOUCH = 2'd0,
    FUNC_CLOSE = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_REFRESHED = 3'd1,
    ST_CLOSED    = 3'd2,
    ST_UNKNOWN   = 3'd3,
    ST_FULL      = 3'd4,
    ST_EXPIRED   = 3'd5,
    ST_NONE_EXP  = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_TOUCH_HIT,
    S_TOUCH_NEW,
    S_CLOSE,
    S_RELINK,
    S_PUSH,
    S_TICK_RD,
    S_TICK_CHK,
    S_TICK_RM
  } state_e;

  // One entry of the table memory.
  typedef struct packed {
    logic [IdBits-1:0]   id;
    logic [31:0]         tstamp;
    logic [SlotBits-1:0] newer;
    logic [SlotBits-1:0] older;
  } entry_t;
endpackage

/* hdl/idle_connection_timeout_table_top.sv */
// Top level of the idle connection timeout table.
// A touch or close scans all TableDepth slots, one memory read per cycle, then issues its
// result word and relinks the list; busy stays high until done, and results are registered.
// A tick reads, checks and removes expired entries in turn from the oldest end; the single
// entry memory sets this pace.
// Reset clears valid bits, list ends, count and timeout (60) at once; no clearing pass.
// The receiver cannot stall: results appear for one cycle with result_valid_o.
module idle_connection_timeout_table_top
  import ictt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [15:0] conn_id_i,
  input  logic [31:0] now_time_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [2:0]  status_o,
  output logic [15:0] result_id_o,
  output logic        last_o
);
  state_e state_q, state_d;
  logic [TableDepth-1:0] valid_q, valid_d;
  logic [SlotBits-1:0] newest_q, newest_d, oldest_q, oldest_d;
  logic [CountBits-1:0] count_q, count_d;
  logic [31:0] timeout_q;
  logic [1:0] func_q, func_d;
  logic [IdBits-1:0] id_q, id_d;
  logic [31:0] now_q, now_d;
  logic [SlotBits-1:0] hit_q, hit_d;
  logic hit_f_q, hit_f_d, free_f_q, free_f_d;
  logic [SlotBits-1:0] free_q, free_d;
  logic [SlotBits:0] addr_cnt_q, addr_cnt_d;
  logic scan_rd_q, scan_rd_d;
  logic [SlotBits-1:0] rd_slot_q;
  entry_t cur_q, cur_d;
  logic [1:0] rl_q, rl_d;
  logic [CountBits-1:0] nexp_q, nexp_d;
  logic we;
  logic [SlotBits-1:0] addr;
  entry_t wdata, rdata;
  logic res_v_d, res_last_d;
  logic [2:0] res_st_d;
  logic [IdBits-1:0] res_id_d;
  logic [32:0] deadline;
  logic pend_q;
  logic [IdBits-1:0] pend_id_q;
  logic flush;
  logic out_v;
  logic [2:0] out_st;
  logic [IdBits-1:0] out_id;
  logic out_last;

  ictt_ram u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign deadline    = {1'b0, rdata.tstamp} + {1'b0, timeout_q};

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      timeout_q <= cfg_data_i;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      valid_q        <= '0;
      newest_q       <= '0;
      oldest_q       <= '0;
      count_q        <= '0;
      scan_rd_q      <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      valid_q        <= valid_d;
      newest_q       <= newest_d;
      oldest_q       <= oldest_d;
      count_q        <= count_d;
      scan_rd_q      <= scan_rd_d;
      result_valid_o <= out_v;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    id_q        <= id_d;
    now_q       <= now_d;
    hit_q       <= hit_d;
    hit_f_q     <= hit_f_d;
    free_f_q    <= free_f_d;
    free_q      <= free_d;
    addr_cnt_q  <= addr_cnt_d;
    rd_slot_q   <= addr;
    cur_q       <= cur_d;
    rl_q        <= rl_d;
    nexp_q      <= nexp_d;
    status_o    <= out_st;
    result_id_o <= out_id;
    last_o      <= out_last;
  end

  // Sequencer: lookup scan, relink steps and tick walk.
  always_comb begin
    state_d    = state_q;
    valid_d    = valid_q;
    newest_d   = newest_q;
    oldest_d   = oldest_q;
    count_d    = count_q;
    func_d     = func_q;
    id_d       = id_q;
    now_d      = now_q;
    hit_d      = hit_q;
    hit_f_d    = hit_f_q;
    free_f_d   = free_f_q;
    free_d     = free_q;
    addr_cnt_d = addr_cnt_q;
    scan_rd_d  = 1'b0;
    cur_d      = cur_q;
    rl_d       = rl_q;
    nexp_d     = nexp_q;
    we         = 1'b0;
    addr       = '0;
    wdata      = cur_q;
    res_v_d    = 1'b0;
    res_st_d   = ST_NONE_EXP;
    res_id_d   = '0;
    res_last_d = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          func_d     = func_i;
          id_d       = conn_id_i[IdBits-1:0];
          now_d      = now_time_i;
          hit_f_d    = 1'b0;
          free_f_d   = 1'b0;
          addr_cnt_d = '0;
          nexp_d     = '0;
          unique case (func_e'(func_i))
            FUNC_TOUCH, FUNC_CLOSE: state_d = S_SCAN;
            FUNC_TICK:              state_d = S_TICK_RD;
            default:                state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        // Issue one read per cycle and compare the word that returns.
        addr = addr_cnt_q[SlotBits-1:0];
        if (addr_cnt_q < (SlotBits+1)'(TableDepth)) begin
          scan_rd_d  = 1'b1;
          addr_cnt_d = addr_cnt_q + 1'b1;
        end
        if (scan_rd_q) begin
          if (valid_q[rd_slot_q] && rdata.id == id_q && !hit_f_q) begin
            hit_f_d = 1'b1;
            hit_d   = rd_slot_q;
            cur_d   = rdata;
          end
          if (!valid_q[rd_slot_q] && !free_f_q) begin
            free_f_d = 1'b1;
            free_d   = rd_slot_q;
          end
        end
        if (!scan_rd_q && addr_cnt_q == (SlotBits+1)'(TableDepth)) begin
          if (func_q == FUNC_CLOSE) begin
            state_d = S_CLOSE;
          end else if (hit_f_q) begin
            state_d = S_TOUCH_HIT;
          end else begin
            state_d = S_TOUCH_NEW;
          end
        end
      end
      S_CLOSE: begin
        res_v_d  = 1'b1;
        res_id_d = id_q;
        if (!hit_f_q) begin
          res_st_d = ST_UNKNOWN;
          state_d  = S_IDLE;
        end else begin
          res_st_d = ST_CLOSED;
          valid_d[hit_q] = 1'b0;
          count_d  = count_q - 1'b1;
          rl_d     = 2'd0;
          state_d  = S_RELINK;
        end
      end
      S_TOUCH_HIT: begin
        // Store the new time, then unlink and push if not already newest.
        addr  = hit_q;
        we    = 1'b1;
        wdata = cur_q;
        wdata.tstamp = now_q;
        cur_d = wdata;
        res_v_d  = 1'b1;
        res_st_d = ST_REFRESHED;
        res_id_d = id_q;
        if (hit_q == newest_q) begin
          state_d = S_IDLE;
        end else begin
          count_d = count_q - 1'b1;
          rl_d    = 2'd0;
          state_d = S_RELINK;
        end
      end
      S_TOUCH_NEW: begin
        res_v_d  = 1'b1;
        res_id_d = id_q;
        if (!free_f_q) begin
          res_st_d = ST_FULL;
          state_d  = S_IDLE;
        end else begin
          res_st_d = ST_ADDED;
          hit_d    = free_q;
          cur_d.id     = id_q;
          cur_d.tstamp = now_q;
          valid_d[free_q] = 1'b1;
          rl_d    = 2'd0;
          state_d = S_PUSH;
        end
      end
      S_RELINK: begin
        // Unlink hit_q (entry in cur_q): read-modify-write the neighbors.
        unique case (rl_q)
          2'd0: begin
            if (hit_q == newest_q) begin
              newest_d = cur_q.older;
              rl_d     = 2'd2;
            end else begin
              addr = cur_q.newer;
              rl_d = 2'd1;
            end
          end
          2'd1: begin
            addr  = cur_q.newer;
            we    = 1'b1;
            wdata = rdata;
            wdata.older = cur_q.older;
            rl_d  = 2'd2;
            if (hit_q == oldest_q) begin
              oldest_d = cur_q.newer;
              rl_d     = 2'd0;
              state_d  = (func_q == FUNC_TOUCH) ? S_PUSH :
                         ((func_q == FUNC_TICK) ? S_TICK_RD : S_IDLE);
            end else begin
              addr = cur_q.newer;
            end
          end
          2'd2: begin
            if (hit_q == oldest_q) begin
              oldest_d = cur_q.newer;
              rl_d     = 2'd0;
              state_d  = (func_q == FUNC_TOUCH) ? S_PUSH :
                         ((func_q == FUNC_TICK) ? S_TICK_RD : S_IDLE);
            end else begin
              addr = cur_q.older;
              rl_d = 2'd3;
            end
          end
          default: begin
            addr  = cur_q.older;
            we    = 1'b1;
            wdata = rdata;
            wdata.newer = cur_q.newer;
            rl_d  = 2'd0;
            state_d = (func_q == FUNC_TOUCH) ? S_PUSH :
                      ((func_q == FUNC_TICK) ? S_TICK_RD : S_IDLE);
          end
        endcase
      end
      S_PUSH: begin
        // Write the entry at the front, then fix the old front's newer link.
        unique case (rl_q)
          2'd0: begin
            addr  = hit_q;
            we    = 1'b1;
            wdata = cur_q;
            wdata.older = newest_q;
            if (count_q == '0) begin
              newest_d = hit_q;
              oldest_d = hit_q;
              count_d  = count_q + 1'b1;
              state_d  = S_IDLE;
            end else begin
              rl_d = 2'd1;
            end
          end
          2'd1: begin
            addr = newest_q;
            rl_d = 2'd2;
          end
          default: begin
            addr  = newest_q;
            we    = 1'b1;
            wdata = rdata;
            wdata.newer = hit_q;
            newest_d = hit_q;
            count_d  = count_q + 1'b1;
            rl_d     = 2'd0;
            state_d  = S_IDLE;
          end
        endcase
      end
      S_TICK_RD: begin
        addr = oldest_q;
        if (count_q == '0 || nexp_q == CountBits'(TableDepth)) begin
          state_d = S_TICK_CHK;
        end else begin
          scan_rd_d = 1'b1;
          state_d   = S_TICK_CHK;
        end
      end
      S_TICK_CHK: begin
        if (scan_rd_q && deadline < {1'b0, now_q}) begin
          cur_d   = rdata;
          hit_d   = oldest_q;
          state_d = S_TICK_RM;
        end else begin
          if (nexp_q == '0) begin
            res_v_d  = 1'b1;
            res_st_d = ST_NONE_EXP;
            res_id_d = '0;
          end
          state_d = S_IDLE;
        end
      end
      S_TICK_RM: begin
        // Report the previous expiry only once we know whether more follow.
        valid_d[hit_q] = 1'b0;
        count_d = count_q - 1'b1;
        nexp_d  = nexp_q + 1'b1;
        rl_d    = 2'd0;
        state_d = S_RELINK;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Expiry results: emitted from a small delay stage so the last flag is known.
  assign flush = (state_q == S_TICK_CHK) && !(scan_rd_q && deadline < {1'b0, now_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (state_q == S_TICK_RM) begin
      pend_q <= 1'b1;
    end else if (flush) begin
      pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_TICK_RM) begin
      pend_id_q <= cur_q.id;
    end
  end

  // Final output mux: pending expiry goes out on the next remove or at the end.
  always_comb begin
    out_v    = res_v_d;
    out_st   = res_st_d;
    out_id   = res_id_d;
    out_last = res_last_d;
    if (pend_q && state_q == S_TICK_RM) begin
      out_v = 1'b1; out_st = ST_EXPIRED; out_id = pend_id_q; out_last = 1'b0;
    end else if (pend_q && flush) begin
      out_v = 1'b1; out_st = ST_EXPIRED; out_id = pend_id_q; out_last = 1'b1;
    end
  end

  property p_count_bound;
    @(posedge clk_i) disable iff (!rst_ni) count_q <= CountBits'(TableDepth);
  endproperty
  a_count_bound: assert property (p_count_bound) else $error("count over depth");

  a_busy_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i != FUNC_NONE) |=> busy) else $error("start not taken");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !start) |=> !pend_q) else $error("expiry left pending");
endmodule

/* hdl/ictt_ram.sv */
// Single port synchronous entry memory with a registered read.
module ictt_ram
  import ictt_pkg::*;
(
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [SlotBits-1:0] addr_i,
  input  entry_t              wdata_i,
  output entry_t              rdata_o
);
  entry_t mem [TableDepth];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
